// File: src/ucdp_pkg.sv
package ucdp_pkg;

    typedef enum logic [2:0] {
        KIND_IFACE = 3'd0,
        KIND_EP    = 3'd1,
        KIND_CLASS = 3'd2,
        KIND_DONE  = 3'd3,
        KIND_ERROR = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        ERR_HDR_SHORT   = 3'd0,
        ERR_IFACES      = 3'd1,
        ERR_EPS         = 3'd2,
        ERR_EP_PLACE    = 3'd3,
        ERR_CLASS_PLACE = 3'd4,
        ERR_ZERO_LEN    = 3'd5,
        ERR_CLASS_OFF   = 3'd6
    } err_t;

    localparam logic [7:0] DT_STRING      = 8'd3;
    localparam logic [7:0] DT_INTERFACE   = 8'd4;
    localparam logic [7:0] DT_ENDPOINT    = 8'd5;
    localparam logic [7:0] DT_QUALIFIER   = 8'd6;
    localparam logic [7:0] DT_OTHER_SPEED = 8'd7;
    localparam logic [7:0] DT_IFACE_POWER = 8'd8;

    localparam int MAX_RUN  = 3;
    localparam int Q_DEPTH  = 4;
    localparam int Q_PTR_W  = $clog2(Q_DEPTH);
    localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        kind_t       kind;
        logic [1:0]  iface_index;
        logic [7:0]  class_code;
        logic [7:0]  subclass_code;
        logic [7:0]  protocol_code;
        logic [4:0]  ep_count;
        logic [3:0]  ep_number;
        logic [1:0]  ep_type;
        logic        ep_dir_in;
        logic [15:0] word_value;
    } rec_t;

    typedef struct packed {
        logic [1:0]               cnt;
        rec_t [MAX_RUN-1:0]       recs;
    } run_t;

    typedef struct packed {
        logic [7:0] class_code;
        logic [7:0] subclass_code;
        logic [7:0] protocol_code;
        logic [4:0] ep_count;
    } pend_t;

endpackage

// File: src/usb_config_descriptor_parser.sv
// path: a byte's records are written into the run queue, then loaded into the output register
// throughput: one byte per cycle while the queue has room; records leave one per cycle
// through the output register while m_tready is high; records of one byte leave in turn
// a four-run queue absorbs bursts; s_tready drops only while that queue is full
// reset: parser waits for a header, all counters clear, class-specific forwarding enabled
module usb_config_descriptor_parser
    import ucdp_pkg::*;
#(
    parameter int MAX_IFACES = 4,
    parameter int MAX_EPS    = 16,
    parameter int BUF_BYTES  = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,   // class_specific_enabled
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,       // data_byte
    input  logic        s_tlast,       // end_of_data
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,       // iface_index, class_code, subclass_code, protocol_code,
                                       // ep_count, ep_number, ep_type, ep_dir_in, word_value
    output logic [2:0]  m_tuser,       // kind
    output logic        m_tlast        // last_of_run
);

    logic run_push;
    run_t push_run;
    logic q_full;
    logic q_valid;
    run_t head;
    logic q_pop;
    rec_t out_rec;

    ucdp_front #(
        .MAX_IFACES (MAX_IFACES),
        .MAX_EPS    (MAX_EPS),
        .BUF_BYTES  (BUF_BYTES)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (s_tvalid),
        .q_full      (q_full),
        .data_byte   (s_tdata),
        .end_of_data (s_tlast),
        .run_push    (run_push),
        .run_out     (push_run)
    );

    ucdp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (run_push),
        .push_run (push_run),
        .full     (q_full),
        .valid    (q_valid),
        .head     (head),
        .pop      (q_pop)
    );

    ucdp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .head      (head),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_rec   (out_rec),
        .out_last  (m_tlast)
    );

    assign s_tready = !q_full;
    assign m_tuser  = out_rec.kind;
    assign m_tdata  = {2'b00, out_rec.word_value, out_rec.ep_dir_in, out_rec.ep_type,
                       out_rec.ep_number, out_rec.ep_count, out_rec.protocol_code,
                       out_rec.subclass_code, out_rec.class_code, out_rec.iface_index};

endmodule

// File: src/ucdp_front.sv
module ucdp_front
    import ucdp_pkg::*;
#(
    parameter int MAX_IFACES = 4,
    parameter int MAX_EPS    = 16,
    parameter int BUF_BYTES  = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       in_valid,
    input  logic       q_full,
    input  logic [7:0] data_byte,
    input  logic       end_of_data,
    output logic       run_push,
    output run_t       run_out
);

    localparam int OFF_MAX = (BUF_BYTES > 255) ? BUF_BYTES : 255;
    localparam int OFF_W   = $clog2(OFF_MAX + 2);
    localparam int PL_W    = $clog2(BUF_BYTES + 1);
    localparam int IFW     = (MAX_IFACES > 1) ? $clog2(MAX_IFACES) : 1;

    localparam int HDR_LENGTH     = 0;
    localparam int HDR_TOTAL_LO   = 2;
    localparam int HDR_TOTAL_HI   = 3;
    localparam int HDR_NUM_IFACES = 4;
    localparam logic [7:0] HDR_MIN_LEN = 8'd5;

    logic                 csen_reg, csen_next;
    logic                 hdr_reg, hdr_next;
    logic                 halted_reg, halted_next;
    logic [OFF_W-1:0]     off_reg, off_next;
    logic [PL_W-1:0]      plim_reg, plim_next;
    logic [7:0]           plo_reg, plo_next;
    logic [7:0]           dlen_reg, dlen_next;
    logic [7:0]           dpos_reg, dpos_next;
    logic [7:0]           dtype_reg, dtype_next;
    logic [5:0][7:0]      fld_reg, fld_next;
    logic [IFW-1:0]       cur_reg, cur_next;
    logic                 seen_reg, seen_next;
    pend_t                pend_reg, pend_next;

    logic                 acc;
    logic [OFF_W-1:0]     off_inc;
    logic [15:0]          total_len;
    run_t                 run_w;
    logic [1:0]           n_w;
    logic                 halt_now;
    rec_t                 rec_w;

    function automatic rec_t iface_rec(logic [IFW-1:0] ifc, pend_t p);
        rec_t r;
        r               = '0;
        r.kind          = KIND_IFACE;
        r.iface_index   = 2'(ifc);
        r.class_code    = p.class_code;
        r.subclass_code = p.subclass_code;
        r.protocol_code = p.protocol_code;
        r.ep_count      = p.ep_count;
        return r;
    endfunction

    function automatic rec_t err_rec(err_t e);
        rec_t r;
        r            = '0;
        r.kind       = KIND_ERROR;
        r.word_value = 16'(e);
        return r;
    endfunction

    assign acc       = in_valid && !q_full;
    assign off_inc   = (&off_reg) ? off_reg : off_reg + OFF_W'(1);
    assign total_len = {data_byte, plo_reg};

    always_comb
    begin
        csen_next   = cfg_wr_en ? cfg_wr_data : csen_reg;
        hdr_next    = hdr_reg;
        halted_next = halted_reg;
        off_next    = off_reg;
        plim_next   = plim_reg;
        plo_next    = plo_reg;
        dlen_next   = dlen_reg;
        dpos_next   = dpos_reg;
        dtype_next  = dtype_reg;
        fld_next    = fld_reg;
        cur_next    = cur_reg;
        seen_next   = seen_reg;
        pend_next   = pend_reg;
        run_w       = '0;
        n_w         = 2'd0;
        halt_now    = 1'b0;
        rec_w       = '0;

        if (acc && !halted_reg)
        begin
            off_next = off_inc;
            if (hdr_reg)
            begin
                if (off_reg == OFF_W'(HDR_LENGTH))
                    dlen_next = (data_byte < HDR_MIN_LEN) ? HDR_MIN_LEN : data_byte;
                if (off_reg == OFF_W'(HDR_TOTAL_LO))
                    plo_next = data_byte;
                if (off_reg == OFF_W'(HDR_TOTAL_HI))
                    plim_next = (total_len > 16'(BUF_BYTES)) ? PL_W'(BUF_BYTES)
                                                             : PL_W'(total_len);
                if (off_reg == OFF_W'(HDR_NUM_IFACES) && 9'(data_byte) > 9'(MAX_IFACES))
                begin
                    run_w.recs[n_w] = err_rec(ERR_IFACES);
                    n_w = n_w + 2'd1;
                    halt_now = 1'b1;
                end
                if (!halt_now)
                begin
                    if (off_inc >= OFF_W'(dlen_next))
                    begin
                        hdr_next  = 1'b0;
                        dpos_next = 8'd0;
                        dlen_next = 8'd0;
                    end
                    else if (end_of_data)
                    begin
                        run_w.recs[n_w] = err_rec(ERR_HDR_SHORT);
                        n_w = n_w + 2'd1;
                        halt_now = 1'b1;
                    end
                end
            end
            else
            begin
                // collect the descriptor byte
                if (dpos_reg == 8'd0)
                begin
                    if (data_byte == 8'd0)
                    begin
                        run_w.recs[n_w] = err_rec(ERR_ZERO_LEN);
                        n_w = n_w + 2'd1;
                        halt_now = 1'b1;
                    end
                    else
                    begin
                        dlen_next  = data_byte;
                        dtype_next = 8'd0;
                        fld_next   = '0;
                    end
                end
                else if (dpos_reg == 8'd1)
                    dtype_next = data_byte;
                else if (dpos_reg < 8'd8)
                    fld_next[3'(dpos_reg[2:0] - 3'd2)] = data_byte;

                if (!halt_now)
                begin
                    if (9'(dpos_reg) + 9'd1 >= 9'(dlen_next))
                    begin
                        dpos_next = 8'd0;
                        // descriptor complete
                        unique case (dtype_next)
                            DT_INTERFACE:
                            begin
                                if (seen_reg)
                                begin
                                    run_w.recs[n_w] = iface_rec(cur_reg, pend_reg);
                                    n_w = n_w + 2'd1;
                                    if (5'(cur_reg) + 5'd1 >= 5'(MAX_IFACES))
                                    begin
                                        run_w.recs[n_w] = err_rec(ERR_IFACES);
                                        n_w = n_w + 2'd1;
                                        halt_now = 1'b1;
                                    end
                                    else
                                        cur_next = cur_reg + IFW'(1);
                                end
                                else
                                begin
                                    seen_next = 1'b1;
                                    cur_next  = '0;
                                end
                                if (!halt_now)
                                begin
                                    if (9'(fld_next[2]) + 9'd1 > 9'(MAX_EPS))
                                    begin
                                        run_w.recs[n_w] = err_rec(ERR_EPS);
                                        n_w = n_w + 2'd1;
                                        halt_now = 1'b1;
                                    end
                                    else
                                    begin
                                        pend_next.class_code    = fld_next[3];
                                        pend_next.subclass_code = fld_next[4];
                                        pend_next.protocol_code = fld_next[5];
                                        pend_next.ep_count      = 5'(fld_next[2]) + 5'd1;
                                    end
                                end
                            end
                            DT_ENDPOINT:
                            begin
                                if (!seen_reg || 5'(fld_next[0][3:0]) >= 5'(MAX_EPS))
                                begin
                                    run_w.recs[n_w] = err_rec(ERR_EP_PLACE);
                                    n_w = n_w + 2'd1;
                                    halt_now = 1'b1;
                                end
                                else
                                begin
                                    rec_w.kind        = KIND_EP;
                                    rec_w.iface_index = 2'(cur_reg);
                                    rec_w.ep_number   = fld_next[0][3:0];
                                    rec_w.ep_type     = fld_next[1][1:0];
                                    rec_w.ep_dir_in   = fld_next[0][7];
                                    rec_w.word_value  = {fld_next[3], fld_next[2]};
                                    run_w.recs[n_w] = rec_w;
                                    n_w = n_w + 2'd1;
                                end
                            end
                            DT_STRING, DT_QUALIFIER, DT_OTHER_SPEED, DT_IFACE_POWER:
                            begin
                                // skipped without a record
                            end
                            default:
                            begin
                                if (!seen_reg)
                                begin
                                    run_w.recs[n_w] = err_rec(ERR_CLASS_PLACE);
                                    n_w = n_w + 2'd1;
                                    halt_now = 1'b1;
                                end
                                else if (csen_reg)
                                begin
                                    rec_w.kind        = KIND_CLASS;
                                    rec_w.iface_index = 2'(cur_reg);
                                    rec_w.class_code  = dtype_next;
                                    rec_w.word_value  = 16'(dlen_next);
                                    run_w.recs[n_w] = rec_w;
                                    n_w = n_w + 2'd1;
                                end
                                else
                                begin
                                    run_w.recs[n_w] = err_rec(ERR_CLASS_OFF);
                                    n_w = n_w + 2'd1;
                                    halt_now = 1'b1;
                                end
                            end
                        endcase
                    end
                    else
                        dpos_next = dpos_reg + 8'd1;
                end
            end

            // end of walk
            if (!halt_now && !hdr_next &&
                (off_inc >= OFF_W'(plim_next) || end_of_data))
            begin
                if (seen_next)
                begin
                    run_w.recs[n_w] = iface_rec(cur_next, pend_next);
                    n_w = n_w + 2'd1;
                end
                rec_w      = '0;
                rec_w.kind = KIND_DONE;
                run_w.recs[n_w] = rec_w;
                n_w = n_w + 2'd1;
                halt_now = 1'b1;
            end
            halted_next = halt_now;
        end

        if (acc && end_of_data)
        begin
            hdr_next    = 1'b1;
            halted_next = 1'b0;
            off_next    = '0;
            plim_next   = '0;
            plo_next    = 8'd0;
            dlen_next   = 8'd0;
            dpos_next   = 8'd0;
            dtype_next  = 8'd0;
            fld_next    = '0;
            cur_next    = '0;
            seen_next   = 1'b0;
            pend_next   = '0;
        end

        run_w.cnt = n_w;
    end

    assign run_push = acc && (n_w != 2'd0);
    assign run_out  = run_w;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            csen_reg   <= 1'b1;
            hdr_reg    <= 1'b1;
            halted_reg <= 1'b0;
            off_reg    <= '0;
            plim_reg   <= '0;
            plo_reg    <= 8'd0;
            dlen_reg   <= 8'd0;
            dpos_reg   <= 8'd0;
            dtype_reg  <= 8'd0;
            fld_reg    <= '0;
            cur_reg    <= '0;
            seen_reg   <= 1'b0;
            pend_reg   <= '0;
        end
        else
        begin
            csen_reg   <= csen_next;
            hdr_reg    <= hdr_next;
            halted_reg <= halted_next;
            off_reg    <= off_next;
            plim_reg   <= plim_next;
            plo_reg    <= plo_next;
            dlen_reg   <= dlen_next;
            dpos_reg   <= dpos_next;
            dtype_reg  <= dtype_next;
            fld_reg    <= fld_next;
            cur_reg    <= cur_next;
            seen_reg   <= seen_next;
            pend_reg   <= pend_next;
        end
    end

endmodule

// File: src/ucdp_queue.sv
module ucdp_queue
    import ucdp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  run_t push_run,
    output logic full,
    output logic valid,
    output run_t head,
    input  logic pop
);

    run_t [Q_DEPTH-1:0]  slot_reg;
    logic [Q_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0]  cnt_reg, cnt_next;

    assign full  = (cnt_reg == Q_CNT_W'(Q_DEPTH));
    assign valid = (cnt_reg != '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + Q_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + Q_PTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + Q_CNT_W'(push) - Q_CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_run;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("run queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> valid)
        else $error("run queue read while empty");
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != Q_CNT_W'(Q_DEPTH)) |->
        (Q_PTR_W'(wr_ptr_reg - rd_ptr_reg) == Q_PTR_W'(cnt_reg)))
        else $error("run queue pointers disagree with fill count");

endmodule

// File: src/ucdp_back.sv
module ucdp_back
    import ucdp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic q_valid,
    input  run_t head,
    output logic q_pop,
    output logic out_valid,
    input  logic out_ready,
    output rec_t out_rec,
    output logic out_last
);

    logic [1:0] sub_reg, sub_next;
    logic       vld_reg, vld_next;
    rec_t       rec_reg, rec_next;
    logic       last_reg, last_next;
    logic       load;
    logic       at_end;

    assign load   = q_valid && (!vld_reg || out_ready);
    assign at_end = (sub_reg == head.cnt - 2'd1);
    assign q_pop  = load && at_end;

    always_comb
    begin
        sub_next  = sub_reg;
        vld_next  = vld_reg;
        rec_next  = rec_reg;
        last_next = last_reg;
        if (load)
        begin
            vld_next  = 1'b1;
            rec_next  = head.recs[sub_reg];
            last_next = at_end;
            sub_next  = at_end ? 2'd0 : sub_reg + 2'd1;
        end
        else if (out_ready)
            vld_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        rec_reg  <= rec_next;
        last_reg <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sub_reg <= 2'd0;
            vld_reg <= 1'b0;
        end
        else
        begin
            sub_reg <= sub_next;
            vld_reg <= vld_next;
        end
    end

    assign out_valid = vld_reg;
    assign out_rec   = rec_reg;
    assign out_last  = last_reg;

    a_run_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_valid |-> (head.cnt != 2'd0))
        else $error("empty run in queue");
    a_sub_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        q_valid |-> (sub_reg < head.cnt))
        else $error("record index past end of run");
    a_sub_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !q_valid |-> (sub_reg == 2'd0))
        else $error("record index left set with no run pending");

endmodule
